// ===== src/string_escape_decoder_unit_assert.svh =====
// Assertion macros used by the string escape decoder top level.
`ifndef STRING_ESCAPE_DECODER_UNIT_ASSERT_SVH
`define STRING_ESCAPE_DECODER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SEDU_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SEDU_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/sed_pkg.sv =====
// Shared types, constants and decode functions for the string escape decoder.
`timescale 1ns / 1ps
`default_nettype none

package sed_pkg;

   // A single input character can produce at most this many results.
   localparam int MaxResults = 5;
   localparam int CountWidth = $clog2(MaxResults + 1);

   // Configuration address: one 32-bit register at byte address 0.
   localparam int CsrAddrWidth = 3;
   localparam int RegIndexWidth = CsrAddrWidth - 2;
   localparam logic [RegIndexWidth-1:0] REG_APPEND_TERMINATOR = '0;

   // Decoder mode codes.
   localparam logic [2:0] MODE_PLAIN = 3'd0;
   localparam logic [2:0] MODE_ESC   = 3'd1;
   localparam logic [2:0] MODE_HEX1  = 3'd2;
   localparam logic [2:0] MODE_HEX2  = 3'd3;
   localparam logic [2:0] MODE_OCT   = 3'd4;

   // Character constants.
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_SEVEN     = 8'h37;
   localparam logic [7:0] BYTE_MAX       = 8'hFF;
   localparam logic [7:0] BYTE_NUL       = 8'h00;

   // Returned by hex_val when the character is not a hex digit.
   localparam logic [4:0] HEX_NONE = 5'd16;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] held_hex_digit;
      logic [7:0] octal_value;
      logic [1:0] octal_digit_count;
   } sed_state_type;

   localparam sed_state_type STATE_RESET = '0;

   // Outcome of decoding one character in plain, escape or octal mode.
   typedef struct packed {
      sed_state_type st;
      logic [1:0]    n;
      logic [7:0]    b0;
      logic [7:0]    b1;
   } sed_feed_type;

   // All results caused by one request, in delivery order.
   typedef struct packed {
      logic [MaxResults-1:0][7:0] bytes;
      logic [CountWidth-1:0]      count;
      logic                       err;
      logic                       last;
   } sed_bundle_type;

   function automatic logic [4:0] hex_val(logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h37;
      end else begin
         return HEX_NONE;
      end
      return {1'b0, d[3:0]};
   endfunction

   function automatic logic is_oct(logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
   endfunction

   // Bit 8 set when the character names an escape; bits 7:0 give its byte.
   function automatic logic [8:0] named(logic [7:0] c);
      logic [8:0] r;
      unique case (c)
         8'h6E:   r = {1'b1, 8'h0A};  // n
         8'h5C:   r = {1'b1, 8'h5C};  // backslash
         8'h62:   r = {1'b1, 8'h08};  // b
         8'h74:   r = {1'b1, 8'h09};  // t
         8'h61:   r = {1'b1, 8'h07};  // a
         8'h3F:   r = {1'b1, 8'h3F};  // question mark
         8'h22:   r = {1'b1, 8'h22};  // double quote
         8'h76:   r = {1'b1, 8'h0B};  // v
         8'h66:   r = {1'b1, 8'h0C};  // f
         8'h72:   r = {1'b1, 8'h0D};  // r
         8'h27:   r = {1'b1, 8'h27};  // single quote
         default: r = 9'h000;
      endcase
      return r;
   endfunction

   // Decode one character starting from plain, escape or octal mode.
   function automatic sed_feed_type feed(sed_state_type s, logic [7:0] c, logic last);
      sed_feed_type f;
      logic [10:0]  t;
      logic [8:0]   nm;
      logic         to_plain;
      f.st     = s;
      f.n      = 2'd0;
      f.b0     = BYTE_NUL;
      f.b1     = BYTE_NUL;
      t        = {s.octal_value, 3'b000} + {8'h00, c[2:0]};
      nm       = named(c);
      to_plain = 1'b1;
      if (s.mode == MODE_OCT) begin
         if (is_oct(c) && s.octal_digit_count != 2'd3 && t <= {3'b000, BYTE_MAX}) begin
            to_plain = 1'b0;
            f.st.octal_value = t[7:0];
            f.st.octal_digit_count = s.octal_digit_count + 2'd1;
            if (s.octal_digit_count == 2'd2 || last) begin
               f.n  = 2'd1;
               f.b0 = t[7:0];
               f.st.octal_value = 8'h00;
               f.st.octal_digit_count = 2'd0;
               f.st.mode = MODE_PLAIN;
            end
         end else begin
            // The escape ends here; the character is then decoded as plain.
            f.n  = 2'd1;
            f.b0 = s.octal_value;
            f.st.octal_value = 8'h00;
            f.st.octal_digit_count = 2'd0;
         end
      end else if (s.mode == MODE_ESC) begin
         to_plain = 1'b0;
         f.st.mode = MODE_PLAIN;
         if (c == CHAR_X) begin
            if (last) begin
               f.n  = 2'd2;
               f.b0 = CHAR_BACKSLASH;
               f.b1 = CHAR_X;
            end else begin
               f.st.mode = MODE_HEX1;
            end
         end else if (is_oct(c)) begin
            if (last) begin
               f.n  = 2'd1;
               f.b0 = {5'b00000, c[2:0]};
            end else begin
               f.st.octal_value = {5'b00000, c[2:0]};
               f.st.octal_digit_count = 2'd1;
               f.st.mode = MODE_OCT;
            end
         end else if (nm[8]) begin
            f.n  = 2'd1;
            f.b0 = nm[7:0];
         end else begin
            f.n  = 2'd2;
            f.b0 = CHAR_BACKSLASH;
            f.b1 = c;
         end
      end
      if (to_plain) begin
         if (c == CHAR_BACKSLASH) begin
            f.st.mode = MODE_ESC;
         end else begin
            f.st.mode = MODE_PLAIN;
            if (f.n == 2'd0) begin
               f.b0 = c;
               f.n  = 2'd1;
            end else begin
               f.b1 = c;
               f.n  = 2'd2;
            end
         end
      end
      return f;
   endfunction

   function automatic sed_bundle_type push_byte(sed_bundle_type b, logic [7:0] v);
      sed_bundle_type r;
      r = b;
      r.bytes[b.count] = v;
      r.count = b.count + CountWidth'(1);
      return r;
   endfunction

   function automatic sed_bundle_type push_feed(sed_bundle_type b, sed_feed_type f);
      sed_bundle_type r;
      r = b;
      if (f.n != 2'd0) begin
         r = push_byte(r, f.b0);
      end
      if (f.n == 2'd2) begin
         r = push_byte(r, f.b1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/sed_decode.sv =====
// Combinational decode of one character into its results and the next decoder state.
`timescale 1ns / 1ps
`default_nettype none

module sed_decode (
   input  sed_pkg::sed_state_type  state,
   input  logic [7:0]              in_char,
   input  logic                    last_char,
   input  logic                    append_terminator,
   output sed_pkg::sed_state_type  state_next,
   output sed_pkg::sed_bundle_type bundle
);
   import sed_pkg::*;

   sed_state_type  plain_st;
   sed_feed_type   f1;
   sed_feed_type   f2;
   logic [4:0]     hex_hi;
   logic [4:0]     hex_lo;
   sed_bundle_type b;
   sed_state_type  nxt;

   always_comb begin
      plain_st      = state;
      plain_st.mode = MODE_PLAIN;
      hex_hi        = hex_val(state.held_hex_digit);
      hex_lo        = hex_val(in_char);
      nxt           = state;
      b             = '0;
      b.last        = last_char;
      f1            = feed(state, in_char, last_char);
      f2            = f1;
      unique case (state.mode)
         MODE_HEX1: begin
            if (last_char) begin
               // The string ends on the character after the x: give back backslash and x first.
               b   = push_byte(b, CHAR_BACKSLASH);
               b   = push_byte(b, CHAR_X);
               f1  = feed(plain_st, in_char, 1'b1);
               b   = push_feed(b, f1);
               nxt = f1.st;
            end else begin
               nxt.held_hex_digit = in_char;
               nxt.mode           = MODE_HEX2;
            end
         end
         MODE_HEX2: begin
            if (hex_hi != HEX_NONE && hex_lo != HEX_NONE) begin
               b   = push_byte(b, {hex_hi[3:0], hex_lo[3:0]});
               nxt = plain_st;
            end else begin
               // Bad hex escape: backslash and x, then both held characters as input.
               b   = push_byte(b, CHAR_BACKSLASH);
               b   = push_byte(b, CHAR_X);
               f1  = feed(plain_st, state.held_hex_digit, 1'b0);
               b   = push_feed(b, f1);
               f2  = feed(f1.st, in_char, last_char);
               b   = push_feed(b, f2);
               nxt = f2.st;
            end
            nxt.held_hex_digit = 8'h00;
         end
         default: begin
            b   = push_feed(b, f1);
            nxt = f1.st;
         end
      endcase
      if (last_char) begin
         if (nxt.mode == MODE_ESC) begin
            b     = push_byte(b, BYTE_NUL);
            b.err = 1'b1;
         end else if (append_terminator) begin
            b = push_byte(b, BYTE_NUL);
         end
         nxt = STATE_RESET;
      end
   end

   assign state_next = nxt;
   assign bundle     = b;

endmodule

`default_nettype wire

// ===== src/sed_rsp_queue.sv =====
// Result register: holds one request's results, hands one out per cycle while ready.
`timescale 1ns / 1ps
`default_nettype none

module sed_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  sed_pkg::sed_bundle_type bundle,
   output logic                    free,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_byte_valid,
   output logic                    rsp_last_of_string,
   output logic                    rsp_unclosed_escape
);
   import sed_pkg::*;

   logic [MaxResults-1:0][7:0] bytes_ff, bytes_in;
   logic [CountWidth-1:0]      count_ff, count_in;
   logic [CountWidth-1:0]      idx_ff, idx_in;
   logic                       err_ff, err_in;
   logic                       last_ff, last_in;
   logic                       has_data;
   logic                       at_final;

   assign has_data = (count_ff != '0);
   assign at_final = (idx_ff == count_ff - CountWidth'(1));
   assign free     = !has_data || (rsp_ready && at_final);

   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      err_in   = err_ff;
      last_in  = last_ff;
      if (load) begin
         bytes_in = bundle.bytes;
         count_in = bundle.count;
         idx_in   = '0;
         err_in   = bundle.err;
         last_in  = bundle.last;
      end else if (has_data && rsp_ready) begin
         if (at_final) begin
            count_in = '0;
            idx_in   = '0;
         end else begin
            idx_in = idx_ff + CountWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
      bytes_ff <= bytes_in;
      err_ff   <= err_in;
      last_ff  <= last_in;
   end

   assign rsp_valid           = has_data;
   assign rsp_out_byte        = bytes_ff[idx_ff];
   assign rsp_unclosed_escape = err_ff && at_final;
   assign rsp_byte_valid      = !(err_ff && at_final);
   assign rsp_last_of_string  = last_ff && at_final;

endmodule

`default_nettype wire

// ===== src/string_escape_decoder_unit.sv =====
// Top level of the string escape decoder: request register, decoder state, CSR and results.
//
//   Channel   Direction  Handshake               Carries
//   req_      in         req_valid / req_ready   in_char, last_char
//   rsp_      out        rsp_valid / rsp_ready   out_byte, byte_valid, last_of_string,
//                                                unclosed_escape
//   csr_      in/out     APB psel/penable        append_terminator at byte address 0
//
// A request is captured in the input register, decoded against the decoder state,
// and all of its results are loaded together into the result register.
// The result register hands out one result per cycle while rsp_ready is high, and
// a request makes at most five results.
// Reset is synchronous and returns the decoder to plain mode with the terminator off.
// A stalled result side holds the result register, which then holds the input register,
// which then drops req_ready; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module string_escape_decoder_unit (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel: one raw character of a string literal body.
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_in_char,
   input  logic                               req_last_char,
   // Result channel: one decoded byte or an error marker per transfer.
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_byte_valid,
   output logic                               rsp_last_of_string,
   output logic                               rsp_unclosed_escape,
   // Configuration port.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sed_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import sed_pkg::*;

   `include "string_escape_decoder_unit_assert.svh"

   // Input register. It is the only place a request waits, so req_ready simply
   // says that this register is empty or is moving on in this cycle.
   logic                 s1_valid_ff, s1_valid_in;
   logic [7:0]           s1_char_ff, s1_char_in;
   logic                 s1_last_ff, s1_last_in;

   // Decoder state carried from one character to the next.
   sed_state_type        state_ff, state_in;
   sed_state_type        state_next;
   sed_bundle_type       bundle;

   logic                 append_ff, append_in;
   logic                 q_free;
   logic                 s1_advance;
   logic                 req_take;
   logic                 csr_write;
   logic [RegIndexWidth-1:0] csr_index;

   // The held request is decoded when the result register can take its results.
   // Requests that make no result still pass through here so the state moves on.
   assign s1_advance = s1_valid_ff && q_free;
   assign req_ready  = !s1_valid_ff || q_free;
   assign req_take   = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_char_in  = s1_char_ff;
      s1_last_in  = s1_last_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_char_in  = req_in_char;
         s1_last_in  = req_last_char;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   assign state_in = s1_advance ? state_next : state_ff;

   sed_decode u_decode (
      .state             (state_ff),
      .in_char           (s1_char_ff),
      .last_char         (s1_last_ff),
      .append_terminator (append_ff),
      .state_next        (state_next),
      .bundle            (bundle)
   );

   sed_rsp_queue u_rsp_queue (
      .clock               (clock),
      .reset               (reset),
      .load                (s1_advance),
      .bundle              (bundle),
      .free                (q_free),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_byte_valid      (rsp_byte_valid),
      .rsp_last_of_string  (rsp_last_of_string),
      .rsp_unclosed_escape (rsp_unclosed_escape)
   );

   // Configuration register. Only bit 0 of the written data is kept, and the
   // low two address bits select bytes within the word, so they are ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[CsrAddrWidth-1:2];
   assign append_in  = (csr_write && csr_index == REG_APPEND_TERMINATOR) ?
                       csr_pwdata[0] : append_ff;

   always_comb begin
      csr_prdata = '0;
      if (csr_index == REG_APPEND_TERMINATOR) begin
         csr_prdata[0] = append_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         state_ff    <= STATE_RESET;
         append_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         state_ff    <= state_in;
         append_ff   <= append_in;
      end
      s1_char_ff <= s1_char_in;
      s1_last_ff <= s1_last_in;
   end

   // The last character of a string always leaves the decoder in plain mode.
   `SEDU_ASSERT_NEXT(a_last_returns_plain, clock, reset, s1_advance && s1_last_ff, state_ff.mode == MODE_PLAIN, "decoder not in plain mode after the end of a string")
   // A request that cannot move on stays in the input register untouched.
   `SEDU_ASSERT_NEXT(a_stalled_request_holds, clock, reset, s1_valid_ff && !s1_advance, s1_valid_ff && $stable(s1_char_ff) && $stable(s1_last_ff), "held request changed while stalled")
   // An error result carries no byte and always closes its string.
   `SEDU_ASSERT_SAME(a_error_closes_string, clock, reset, rsp_valid && rsp_unclosed_escape, rsp_last_of_string && !rsp_byte_valid, "error result is not the final result of its string")

endmodule

`default_nettype wire
